FILE: rtl/pcfe_pkg.sv
// Shared constants, codes and controller/datapath interface types for the color fade engine.
package pcfe_pkg;

  // Grid geometry
  localparam int unsigned GRID_WIDTH  = 64;
  localparam int unsigned GRID_HEIGHT = 64;
  localparam int unsigned NUM_CELLS   = GRID_WIDTH * GRID_HEIGHT;
  localparam int unsigned ADDR_W      = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

  // Field widths
  localparam int unsigned CELL_W = 12;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned FRAC_W = 17;
  localparam int unsigned Q88_W  = 16;

  // Stream packing
  localparam int unsigned S_DATA_W = 56;
  localparam int unsigned M_DATA_W = 24;

  // Fixed-point constants
  localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'd65536;
  localparam logic [Q88_W-1:0]  WHITE_Q88 = 16'd65280;

  // Command codes carried in tuser
  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_TICK = 2'd1,
    OP_SNAP = 2'd2,
    OP_READ = 2'd3
  } op_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_SWEEP,
    ST_DRAIN,
    ST_RD_ADDR,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic clear_wr;
    logic clr_cnt;
    logic inc_cnt;
    logic sweep_rd;
    logic set_wr;
    logic cell_rd;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic cnt_last;
    logic pipe_busy;
  } dp_sts_t;

endpackage

FILE: rtl/pcfe_ctrl.sv
// Controller state machine: clearing pass, command dispatch, sweeps and result hand-off.
module pcfe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  pcfe_pkg::dp_sts_t sts,
  output pcfe_pkg::dp_cmd_t cmd
);
  import pcfe_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;

  // State register and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.cnt_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (sts.op)
          OP_TICK, OP_SNAP: state_next = ST_SWEEP;
          OP_READ:          state_next = ST_RD_ADDR;
          default:          state_next = ST_FINISH;
        endcase
      end
      ST_SWEEP: begin
        if (sts.cnt_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) state_next = ST_FINISH;
      end
      ST_RD_ADDR: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        cmd.inc_cnt  = 1'b1;
      end
      ST_IDLE: begin
        s_tready      = 1'b1;
        cmd.load_item = s_tvalid;
      end
      ST_DISPATCH: begin
        cmd.clr_cnt = 1'b1;
        cmd.set_wr  = (sts.op == OP_SET);
      end
      ST_SWEEP: begin
        cmd.sweep_rd = 1'b1;
        cmd.inc_cnt  = 1'b1;
      end
      ST_RD_ADDR: begin
        cmd.cell_rd = 1'b1;
      end
      ST_FINISH: begin
        cmd.load_out = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Accepted item always moves on to dispatch
  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_DISPATCH)
    else $error("accepted item not dispatched");

  // A result is never loaded over one still waiting
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("result overwritten");

  // Last sweep address leads into the drain
  a_sweep_drain: assert property (@(posedge clk) disable iff (rst)
    state == ST_SWEEP && sts.cnt_last |=> state == ST_DRAIN)
    else $error("sweep did not end in drain");

  // Nothing accepted during the clearing pass
  a_clear_block: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !s_tready)
    else $error("item accepted during clear");

endmodule

FILE: rtl/pcfe_datapath.sv
// Datapath: target and shown memories, sweep counter, fade pipeline and result rounding.
module pcfe_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [pcfe_pkg::S_DATA_W-1:0]   s_tdata,
  input  logic [1:0]                      s_tuser,
  output logic [pcfe_pkg::M_DATA_W-1:0]   m_tdata,
  input  pcfe_pkg::dp_cmd_t               cmd,
  output pcfe_pkg::dp_sts_t               sts
);
  import pcfe_pkg::*;

  // Latched item
  op_t               op_q;
  logic [CELL_W-1:0] cell_q;
  logic [BYTE_W-1:0] red_q, green_q, blue_q;
  logic [FRAC_W-1:0] frac_q;
  logic [FRAC_W-1:0] frac_in;
  logic              cell_ok;
  logic [ADDR_W-1:0] cell_addr;

  // Memories
  logic [3*BYTE_W-1:0] tmem [NUM_CELLS];
  logic [3*Q88_W-1:0]  smem [NUM_CELLS];
  logic [3*BYTE_W-1:0] t_rdata;
  logic [3*Q88_W-1:0]  s_rdata;

  // Sweep counter and pipeline
  logic [ADDR_W-1:0] cnt;
  logic              v1, v2;
  logic [ADDR_W-1:0] addr1, addr2;
  logic signed [34:0]  prod   [3];
  logic [Q88_W-1:0]    d_q    [3];
  logic [BYTE_W-1:0]   t_q    [3];
  logic signed [16:0]  diff   [3];
  logic signed [17:0]  frac_s;
  logic signed [18:0]  step   [3];
  logic signed [19:0]  nd     [3];
  logic [3*Q88_W-1:0]  s_wdata;

  // Write port selects
  logic                t_we;
  logic [ADDR_W-1:0]   t_waddr;
  logic [3*BYTE_W-1:0] t_wdata;
  logic                s_we;
  logic [ADDR_W-1:0]   s_waddr;
  logic [3*Q88_W-1:0]  s_wdata_mux;
  logic [ADDR_W-1:0]   s_raddr;

  // Result rounding
  logic [Q88_W:0]      rsum   [3];
  logic [BYTE_W-1:0]   rbyte  [3];

  assign frac_in   = s_tdata[52:36];
  assign cell_ok   = (32'(cell_q) < NUM_CELLS);
  assign cell_addr = ADDR_W'(cell_q);
  assign frac_s    = $signed({1'b0, frac_q});

  // Item registers; fraction saturated to one on the way in
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q    <= op_t'(s_tuser);
      cell_q  <= s_tdata[11:0];
      red_q   <= s_tdata[19:12];
      green_q <= s_tdata[27:20];
      blue_q  <= s_tdata[35:28];
      frac_q  <= (frac_in > FRAC_ONE) ? FRAC_ONE : frac_in;
    end
  end

  // Sweep address counter
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_cnt) begin
      cnt <= '0;
    end else if (cmd.inc_cnt) begin
      cnt <= cnt + ADDR_W'(1);
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.sweep_rd;
      v2 <= v1;
    end
  end

  // Target memory
  assign t_we    = cmd.clear_wr || (cmd.set_wr && cell_ok);
  assign t_waddr = cmd.clear_wr ? cnt : cell_addr;
  assign t_wdata = cmd.clear_wr ? {3{8'hFF}} : {blue_q, green_q, red_q};

  always_ff @(posedge clk) begin
    if (t_we) tmem[t_waddr] <= t_wdata;
    if (cmd.sweep_rd) t_rdata <= tmem[cnt];
  end

  // Shown memory
  assign s_we        = cmd.clear_wr || v2;
  assign s_waddr     = cmd.clear_wr ? cnt : addr2;
  assign s_wdata_mux = cmd.clear_wr ? {3{WHITE_Q88}} : s_wdata;
  assign s_raddr     = cmd.cell_rd ? cell_addr : cnt;

  always_ff @(posedge clk) begin
    if (s_we) smem[s_waddr] <= s_wdata_mux;
    if (cmd.sweep_rd || cmd.cell_rd) s_rdata <= smem[s_raddr];
  end

  // Stage b: difference times fraction, one multiplier per channel
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff[c] = $signed({1'b0, t_rdata[c*BYTE_W +: BYTE_W], 8'h00})
              - $signed({1'b0, s_rdata[c*Q88_W +: Q88_W]});
    end
  end

  always_ff @(posedge clk) begin
    addr1 <= cnt;
    addr2 <= addr1;
    for (int c = 0; c < 3; c++) begin
      prod[c] <= 35'(diff[c] * frac_s);
      d_q[c]  <= s_rdata[c*Q88_W +: Q88_W];
      t_q[c]  <= t_rdata[c*BYTE_W +: BYTE_W];
    end
  end

  // Stage c: floor shift, add and clamp, or snap to target
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      step[c] = prod[c][34:16];
      nd[c]   = $signed({4'b0000, d_q[c]}) + {step[c][18], step[c]};
      if (op_q == OP_SNAP) begin
        s_wdata[c*Q88_W +: Q88_W] = {t_q[c], 8'h00};
      end else if (nd[c][19]) begin
        s_wdata[c*Q88_W +: Q88_W] = '0;
      end else if (nd[c] > $signed({4'b0000, WHITE_Q88})) begin
        s_wdata[c*Q88_W +: Q88_W] = WHITE_Q88;
      end else begin
        s_wdata[c*Q88_W +: Q88_W] = nd[c][15:0];
      end
    end
  end

  // Round to bytes with saturation
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rsum[c]  = {1'b0, s_rdata[c*Q88_W +: Q88_W]} + 17'd128;
      rbyte[c] = rsum[c][16] ? 8'hFF : rsum[c][15:8];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (op_q == OP_READ && cell_ok) begin
        m_tdata <= {rbyte[2], rbyte[1], rbyte[0]};
      end else begin
        m_tdata <= '0;
      end
    end
  end

  // Status
  assign sts.op        = op_q;
  assign sts.cnt_last  = (cnt == ADDR_W'(NUM_CELLS - 1));
  assign sts.pipe_busy = v1 || v2;

endmodule

FILE: rtl/pixel_color_fade_engine_unit.sv
// Top level of the pixel color fade engine: controller plus datapath.
//
// The engine holds a target RGB byte triple and a Q8.8 shown color for each of
// 4096 cells (64 by 64) in two single-port-read, single-port-write memories.
// After reset a clearing pass writes white into both memories, one cell a
// cycle; no item is taken during that pass. Items are then handled one at
// a time, and a fade tick or snap walks every cell once through a
// three-stage read, multiply, write-back pipeline with one cell (three channel
// multipliers) per cycle. The sweep is bounded by the one read port of each
// memory. A new item is taken while the previous result still waits in the
// output register.
module pixel_color_fade_engine_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // cell_index[11:0], red[19:12], green[27:20], blue[35:28],
  // blend_fraction[52:36], zero[55:53]
  input  logic [pcfe_pkg::S_DATA_W-1:0] s_tdata,
  // cmd[1:0]
  input  logic [1:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16]
  output logic [pcfe_pkg::M_DATA_W-1:0] m_tdata
);
  import pcfe_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  pcfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcfe_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata),
    .cmd     (cmd),
    .sts     (sts)
  );

endmodule
